>>> hdl/gcd_pkg.sv
// ---------------------------------------------------------------------------
// gcd_pkg: shared types, constants and arithmetic helpers
// Fixed-point formats, CORDIC arctangent table and the rounded Q30 product
// used by the great-circle distance pipeline.
// ---------------------------------------------------------------------------
package gcd_pkg;

   localparam int LANES               = 4;
   localparam int ANG_W               = 36;
   localparam int TRIG_W              = 32;
   localparam int MUL_W               = 34;
   localparam int SQ_W                = 61;
   localparam int SQ_STEPS            = 31;
   localparam int CORDIC_ITER_DEFAULT = 24;

   typedef logic signed [ANG_W-1:0]  angle_type;
   typedef logic signed [TRIG_W-1:0] trig_type;
   typedef logic signed [MUL_W-1:0]  wide_type;

   localparam angle_type PI_Q30      = 36'sd3373259422;
   localparam angle_type HALF_PI_Q30 = 36'sd1686629711;
   localparam trig_type  GAIN_Q30    = 32'sd652032874;
   localparam trig_type  ONE_Q30     = 32'sd1073741824;

   // Arctangent of 2^-i in Q30; small angles collapse to 2^(30-i).
   function automatic angle_type atan_step(input int i);
      angle_type t;
      t = '0;
      case (i)
         0: t = 36'sd843314857;
         1: t = 36'sd497837829;
         2: t = 36'sd263043837;
         3: t = 36'sd133525159;
         4: t = 36'sd67021687;
         5: t = 36'sd33543516;
         6: t = 36'sd16775851;
         7: t = 36'sd8388437;
         8: t = 36'sd4194283;
         9: t = 36'sd2097149;
         default: begin
            if (i <= 30) t = angle_type'(1) <<< (30 - i);
         end
      endcase
      return t;
   endfunction

   // Q30 product, magnitude rounded half away from zero.
   function automatic wide_type mul30(input wide_type a, input wide_type b);
      logic               neg;
      logic [MUL_W-1:0]   ma;
      logic [MUL_W-1:0]   mb;
      logic [2*MUL_W-1:0] p;
      logic [MUL_W-1:0]   r;
      neg = a[MUL_W-1] ^ b[MUL_W-1];
      ma  = a[MUL_W-1] ? MUL_W'(-a) : MUL_W'(a);
      mb  = b[MUL_W-1] ? MUL_W'(-b) : MUL_W'(b);
      p   = (2*MUL_W)'(ma) * (2*MUL_W)'(mb);
      p   = p + ((2*MUL_W)'(1) << 29);
      r   = p[30 +: MUL_W];
      return neg ? -wide_type'(r) : wide_type'(r);
   endfunction

endpackage

>>> hdl/gcd_sincos.sv
// ---------------------------------------------------------------------------
// gcd_sincos: pipelined rotation CORDIC, one lane per coordinate
// Reduces each angle by a half turn, then runs one micro-rotation a stage.
// ---------------------------------------------------------------------------
module gcd_sincos
   import gcd_pkg::*;
#(
   parameter int ITER = CORDIC_ITER_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  angle_type in_angle [LANES],
   output logic      out_valid,
   output trig_type  out_sin [LANES],
   output trig_type  out_cos [LANES]
);

   logic [ITER+1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[ITER:0], in_valid};
      end
   end

   assign out_valid = valid_ff[ITER+1];

   genvar l, i;
   generate
      for (l = 0; l < LANES; l++) begin : g_lane
         angle_type z0_in, z0_ff;
         logic      neg0_in, neg0_ff;
         trig_type  x_ff [ITER];
         trig_type  y_ff [ITER];
         angle_type z_ff [ITER];
         logic      neg_ff [ITER];
         trig_type  sin_ff, cos_ff;

         // Fold into the half-turn around zero, remember the sign flip.
         always_comb begin
            angle_type a;
            a = in_angle[l];
            neg0_in = 1'b0;
            if (a > PI_Q30) a = a - (PI_Q30 <<< 1);
            else if (a < -PI_Q30) a = a + (PI_Q30 <<< 1);
            if (a > HALF_PI_Q30) begin
               a = a - PI_Q30;
               neg0_in = 1'b1;
            end else if (a < -HALF_PI_Q30) begin
               a = a + PI_Q30;
               neg0_in = 1'b1;
            end
            z0_in = a;
         end

         always_ff @(posedge clock) begin
            z0_ff   <= z0_in;
            neg0_ff <= neg0_in;
         end

         for (i = 0; i < ITER; i++) begin : g_stage
            trig_type  xp, yp, x_in, y_in;
            angle_type zp, z_in;
            logic      np;
            if (i == 0) begin : g_first
               assign xp = GAIN_Q30;
               assign yp = '0;
               assign zp = z0_ff;
               assign np = neg0_ff;
            end else begin : g_next
               assign xp = x_ff[i-1];
               assign yp = y_ff[i-1];
               assign zp = z_ff[i-1];
               assign np = neg_ff[i-1];
            end
            always_comb begin
               if (!zp[ANG_W-1]) begin
                  x_in = xp - (yp >>> i);
                  y_in = yp + (xp >>> i);
                  z_in = zp - atan_step(i);
               end else begin
                  x_in = xp + (yp >>> i);
                  y_in = yp - (xp >>> i);
                  z_in = zp + atan_step(i);
               end
            end
            always_ff @(posedge clock) begin
               x_ff[i]   <= x_in;
               y_ff[i]   <= y_in;
               z_ff[i]   <= z_in;
               neg_ff[i] <= np;
            end
         end

         always_ff @(posedge clock) begin
            cos_ff <= neg_ff[ITER-1] ? -x_ff[ITER-1] : x_ff[ITER-1];
            sin_ff <= neg_ff[ITER-1] ? -y_ff[ITER-1] : y_ff[ITER-1];
         end

         assign out_sin[l] = sin_ff;
         assign out_cos[l] = cos_ff;
      end
   endgenerate

endmodule

>>> hdl/gcd_acos.sv
// ---------------------------------------------------------------------------
// gcd_acos: pipelined arccosine
// Square root of 1 - c*c one result bit a stage, then vectoring CORDIC.
// ---------------------------------------------------------------------------
module gcd_acos
   import gcd_pkg::*;
#(
   parameter int ITER = CORDIC_ITER_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  trig_type         in_cos,
   output logic             out_valid,
   output logic [ANG_W-2:0] out_theta
);

   localparam int DEPTH = SQ_STEPS + ITER + 3;

   logic [DEPTH-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[DEPTH-2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[DEPTH-1];

   // (1 - c)(1 + c), both factors non-negative after the clamp upstream
   logic [SQ_W-1:0] v0_in, v0_ff;
   trig_type        c0_ff;

   assign v0_in = SQ_W'((64'(ONE_Q30 - in_cos)) * (64'(ONE_Q30 + in_cos)));

   always_ff @(posedge clock) begin
      v0_ff <= v0_in;
      c0_ff <= in_cos;
   end

   logic [SQ_W-1:0] v_ff [SQ_STEPS];
   logic [SQ_W-1:0] r_ff [SQ_STEPS];
   trig_type        c_ff [SQ_STEPS];

   genvar k, i;
   generate
      for (k = 0; k < SQ_STEPS; k++) begin : g_sqrt
         localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 1 - 2*k);
         logic [SQ_W-1:0] vp, rp, v_in, r_in, trial;
         trig_type        cp;
         if (k == 0) begin : g_first
            assign vp = v0_ff;
            assign rp = '0;
            assign cp = c0_ff;
         end else begin : g_next
            assign vp = v_ff[k-1];
            assign rp = r_ff[k-1];
            assign cp = c_ff[k-1];
         end
         assign trial = rp + BIT;
         always_comb begin
            if (vp >= trial) begin
               v_in = vp - trial;
               r_in = (rp >> 1) + BIT;
            end else begin
               v_in = vp;
               r_in = rp >> 1;
            end
         end
         always_ff @(posedge clock) begin
            v_ff[k] <= v_in;
            r_ff[k] <= r_in;
            c_ff[k] <= cp;
         end
      end
   endgenerate

   // Start vector (c, sqrt(1-c*c)); rotate a quarter turn when c is negative.
   trig_type  sq_root, xs_in, ys_in, xs_ff, ys_ff;
   angle_type zs_in, zs_ff;

   assign sq_root = TRIG_W'(r_ff[SQ_STEPS-1]);

   always_comb begin
      if (c_ff[SQ_STEPS-1][TRIG_W-1]) begin
         xs_in = sq_root;
         ys_in = -c_ff[SQ_STEPS-1];
         zs_in = HALF_PI_Q30;
      end else begin
         xs_in = c_ff[SQ_STEPS-1];
         ys_in = sq_root;
         zs_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      xs_ff <= xs_in;
      ys_ff <= ys_in;
      zs_ff <= zs_in;
   end

   trig_type  x_ff [ITER];
   trig_type  y_ff [ITER];
   angle_type z_ff [ITER];

   generate
      for (i = 0; i < ITER; i++) begin : g_stage
         trig_type  xp, yp, x_in, y_in;
         angle_type zp, z_in;
         if (i == 0) begin : g_first
            assign xp = xs_ff;
            assign yp = ys_ff;
            assign zp = zs_ff;
         end else begin : g_next
            assign xp = x_ff[i-1];
            assign yp = y_ff[i-1];
            assign zp = z_ff[i-1];
         end
         always_comb begin
            if (yp > 0) begin
               x_in = xp + (yp >>> i);
               y_in = yp - (xp >>> i);
               z_in = zp + atan_step(i);
            end else begin
               x_in = xp - (yp >>> i);
               y_in = yp + (xp >>> i);
               z_in = zp - atan_step(i);
            end
         end
         always_ff @(posedge clock) begin
            x_ff[i] <= x_in;
            y_ff[i] <= y_in;
            z_ff[i] <= z_in;
         end
      end
   endgenerate

   logic [ANG_W-2:0] theta_ff;

   always_ff @(posedge clock) begin
      theta_ff <= z_ff[ITER-1][ANG_W-1] ? '0 : z_ff[ITER-1][ANG_W-2:0];
   end

   assign out_theta = theta_ff;

endmodule

>>> hdl/great_circle_distance.sv
// ---------------------------------------------------------------------------
// great_circle_distance: spherical law of cosines distance pipeline
// Two points in 1e-7 degree units in, distance in 1/1024 mile out.
// ---------------------------------------------------------------------------
// A transaction is taken at every rising edge with start high and busy low;
// busy is high only in the cycle after reset, so a new coordinate pair can
// enter on every clock. Each transaction returns exactly one distance,
// marked by a one-cycle rsp_valid strobe. The receiver cannot stall the
// block: results are shown once and must be captured on that edge. The
// pipeline depth is set by the two CORDIC chains (one micro-rotation per
// stage), the 31-stage square root and the conversion, product and scaling
// stages; results leave in the order the transactions came in.
// ---------------------------------------------------------------------------
module great_circle_distance
   import gcd_pkg::*;
#(
   parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [30:0] req_first_latitude,
   input  logic signed [31:0] req_first_longitude,
   input  logic signed [30:0] req_second_latitude,
   input  logic signed [31:0] req_second_longitude,
   output logic               rsp_valid,
   output logic [23:0]        rsp_distance_miles
);

   // Degrees-to-radians scale: units * PI_Q30 / 1.8e9, rounded half away.
   localparam logic [63:0] DEG_SCALE  = 64'd1800000000;
   localparam logic [63:0] HALF_SCALE = 64'd900000000;
   localparam logic [63:0] RECIP_FULL = (64'd3373259422 << 32) / 64'd1800000000;
   localparam logic [32:0] RECIP_K    = RECIP_FULL[32:0];
   localparam logic [31:0] PI_U       = 32'd3373259422;
   // theta * 39631 / (10 * 2^20): a 2^20 shift then a divide by ten
   localparam logic [15:0] DIST_MUL   = 16'd39631;
   localparam logic [31:0] RECIP_TEN  = 32'hCCCCCCCD;
   localparam logic [23:0] DIST_MAX   = 24'd12750000;

   logic busy_ff;
   logic accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign accept = start & ~busy_ff;

   // Conversion to Q30 radians, three stages: estimate, back-multiply, fix up.
   logic signed [31:0] coord [LANES];
   logic [2:0]         cv_valid_ff;
   logic               cv_neg_in  [LANES];
   logic               cv_neg_ff  [LANES];
   logic               cv_neg2_ff [LANES];
   logic [32:0]        cv_est_in  [LANES];
   logic [32:0]        cv_est_ff  [LANES];
   logic [32:0]        cv_est2_ff [LANES];
   logic [63:0]        cv_num_in  [LANES];
   logic [63:0]        cv_num_ff  [LANES];
   logic [63:0]        cv_num2_ff [LANES];
   logic [63:0]        cv_prod_in [LANES];
   logic [63:0]        cv_prod_ff [LANES];
   angle_type          angle_in   [LANES];
   angle_type          angle_ff   [LANES];

   assign coord[0] = 32'(req_first_latitude);
   assign coord[1] = req_first_longitude;
   assign coord[2] = 32'(req_second_latitude);
   assign coord[3] = req_second_longitude;

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_valid_ff <= '0;
      end else begin
         cv_valid_ff <= {cv_valid_ff[1:0], accept};
      end
   end

   always_comb begin
      logic [31:0] mag;
      logic [64:0] scaled;
      logic [63:0] rem;
      logic [32:0] quo;
      for (int l = 0; l < LANES; l++) begin
         // estimate from the reciprocal; it falls short by at most two
         cv_neg_in[l]  = coord[l][31];
         mag           = coord[l][31] ? 32'(-coord[l]) : 32'(coord[l]);
         scaled        = 65'(mag) * 65'(RECIP_K);
         cv_est_in[l]  = scaled[64:32];
         cv_num_in[l]  = 64'(mag) * 64'(PI_U) + HALF_SCALE;
         // back-multiply the estimate
         cv_prod_in[l] = 64'(cv_est_ff[l]) * DEG_SCALE;
         // correct by the remainder
         rem           = cv_num2_ff[l] - cv_prod_ff[l];
         quo           = cv_est2_ff[l];
         if (rem >= (DEG_SCALE << 1)) quo = quo + 33'd2;
         else if (rem >= DEG_SCALE) quo = quo + 33'd1;
         angle_in[l]   = cv_neg2_ff[l] ? -ANG_W'(quo) : ANG_W'(quo);
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < LANES; l++) begin
         cv_neg_ff[l]  <= cv_neg_in[l];
         cv_est_ff[l]  <= cv_est_in[l];
         cv_num_ff[l]  <= cv_num_in[l];
         cv_neg2_ff[l] <= cv_neg_ff[l];
         cv_est2_ff[l] <= cv_est_ff[l];
         cv_num2_ff[l] <= cv_num_ff[l];
         cv_prod_ff[l] <= cv_prod_in[l];
         angle_ff[l]   <= angle_in[l];
      end
   end

   // Sine and cosine of all four angles.
   logic     sc_valid;
   trig_type sc_sin [LANES];
   trig_type sc_cos [LANES];

   gcd_sincos #(
      .ITER (CORDIC_ITERATIONS)
   ) u_sincos (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cv_valid_ff[2]),
      .in_angle  (angle_ff),
      .out_valid (sc_valid),
      .out_sin   (sc_sin),
      .out_cos   (sc_cos)
   );

   // Cosine sum: cl1*cl2 * (co1*co2 + so1*so2) + sl1*sl2, four stages.
   logic [3:0] pr_valid_ff;
   wide_type   cc_ff, ss_ff, cl_ff, sl_ff;
   wide_type   lon_ff, cl2_ff, sl2_ff;
   wide_type   m_ff, sl3_ff;
   trig_type   cos_in, cos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_valid_ff <= '0;
      end else begin
         pr_valid_ff <= {pr_valid_ff[2:0], sc_valid};
      end
   end

   always_comb begin
      logic signed [MUL_W:0] sum;
      sum = (MUL_W+1)'(m_ff) + (MUL_W+1)'(sl3_ff);
      // clamp to the arccosine's domain
      if (sum > (MUL_W+1)'(ONE_Q30)) cos_in = ONE_Q30;
      else if (sum < -(MUL_W+1)'(ONE_Q30)) cos_in = -ONE_Q30;
      else cos_in = TRIG_W'(sum);
   end

   always_ff @(posedge clock) begin
      cc_ff  <= mul30(MUL_W'(sc_cos[1]), MUL_W'(sc_cos[3]));
      ss_ff  <= mul30(MUL_W'(sc_sin[1]), MUL_W'(sc_sin[3]));
      cl_ff  <= mul30(MUL_W'(sc_cos[0]), MUL_W'(sc_cos[2]));
      sl_ff  <= mul30(MUL_W'(sc_sin[0]), MUL_W'(sc_sin[2]));
      lon_ff <= cc_ff + ss_ff;
      cl2_ff <= cl_ff;
      sl2_ff <= sl_ff;
      m_ff   <= mul30(cl2_ff, lon_ff);
      sl3_ff <= sl2_ff;
      cos_ff <= cos_in;
   end

   // Central angle.
   logic             ac_valid;
   logic [ANG_W-2:0] theta;

   gcd_acos #(
      .ITER (CORDIC_ITERATIONS)
   ) u_acos (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pr_valid_ff[3]),
      .in_cos    (cos_ff),
      .out_valid (ac_valid),
      .out_theta (theta)
   );

   // Scale to 1/1024 mile with round half up, then saturate.
   logic [1:0]  ds_valid_ff;
   logic [50:0] ds_t_in, ds_t_ff;
   logic [30:0] ds_u;
   logic [62:0] ds_q_in, ds_q_ff;
   logic [27:0] ds_div;
   logic        rsp_valid_ff;
   logic [23:0] dist_in, dist_ff;

   assign ds_t_in = 51'(theta) * 51'(DIST_MUL) + (51'd5 << 20);
   assign ds_u    = ds_t_ff[50:20];
   assign ds_q_in = 63'(ds_u) * 63'(RECIP_TEN);
   assign ds_div  = ds_q_ff[62:35];
   assign dist_in = (ds_div > 28'(DIST_MAX)) ? DIST_MAX : ds_div[23:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         ds_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ds_valid_ff  <= {ds_valid_ff[0], ac_valid};
         rsp_valid_ff <= ds_valid_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      ds_t_ff <= ds_t_in;
      ds_q_ff <= ds_q_in;
      dist_ff <= dist_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_distance_miles = dist_ff;

endmodule
